FILE: hdl/prfq_pkg.sv
// ----------------------------------------------------------------------------
// prfq_pkg: shared types and constants of the priority frame send queue.
// Holds the slot descriptor, the per-cell control word and the command codes.
// ----------------------------------------------------------------------------
package prfq_pkg;

  localparam int unsigned StoreDepthDefault  = 32;
  localparam int unsigned HeaderBytesDefault = 2;
  localparam int unsigned MaxResults         = 32;

  localparam logic [20:0] PacketLimitReset = 21'(1 * 1024 * 1024);

  localparam logic [2:0] FuncStage  = 3'd0;
  localparam logic [2:0] FuncCommit = 3'd1;
  localparam logic [2:0] FuncSend   = 3'd2;
  localparam logic [2:0] FuncAck    = 3'd3;
  localparam logic [2:0] FuncClear  = 3'd4;

  typedef struct packed {
    logic [15:0] tag;
    logic [7:0]  prio;
    logic [19:0] len;
    logic [15:0] pkt;
    logic        flag;
  } slot_t;

  typedef struct packed {
    logic shift;
    logic ins;
    logic wr;
    logic clr;
  } cell_ctrl_t;

endpackage

FILE: hdl/prfq_cell.sv
// ----------------------------------------------------------------------------
// prfq_cell: one slot of the descriptor row.
// Loads a staged frame, clears its packet id, or takes its neighbor's slot
// (or the reworked head slot) when the row rotates.
// ----------------------------------------------------------------------------
module prfq_cell (
  input  logic                 clk_i,
  input  prfq_pkg::cell_ctrl_t ctrl_i,
  input  prfq_pkg::slot_t      nbr_i,
  input  prfq_pkg::slot_t      head_i,
  input  prfq_pkg::slot_t      wdata_i,
  output prfq_pkg::slot_t      slot_o
);
  import prfq_pkg::*;

  slot_t slot_d, slot_q;

  always_comb begin
    slot_d = slot_q;
    if (ctrl_i.wr) begin
      slot_d = wdata_i;
    end else if (ctrl_i.clr) begin
      slot_d.pkt = '0;
    end else if (ctrl_i.shift) begin
      slot_d = ctrl_i.ins ? head_i : nbr_i;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

  assign slot_o = slot_q;

endmodule

FILE: hdl/priority_frame_send_queue_top.sv
// ----------------------------------------------------------------------------
// priority_frame_send_queue_top: committed frame queue with packet picking.
// Frame descriptors sit in a row of cells that rotates toward the head.
// ----------------------------------------------------------------------------
// Commands arrive on the s_axis channel, func in tuser and the frame fields
// in tdata. Results leave on m_axis, one word per result, tlast on the final
// word of a command. The packet limit is written through cfg_we_i.
// Stage, commit, clear and unknown commands give their result in the cycle
// after they are taken. Send and acknowledge rotate the whole used part
// of the row, one slot a cycle, through the head cell. The second pass of
// a send emits the picked tags and pauses while the receiver stalls.
// Only one command is in work at a time; s_axis_tready is low meanwhile and
// while a result word waits in the output register.
// Reset empties the queue, sets both priority gates to one and the packet
// limit to its reset value; no clearing pass is needed.
// ----------------------------------------------------------------------------
module priority_frame_send_queue_top #(
  parameter int unsigned STORE_DEPTH  = prfq_pkg::StoreDepthDefault,
  parameter int unsigned HEADER_BYTES = prfq_pkg::HeaderBytesDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [20:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tag[15:0], priority[23:16], length[43:24], packet_id[59:44], zero fill.
  input  logic [63:0] s_axis_tdata,
  // func[2:0].
  input  logic [2:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // count[5:0], sent_tag[21:6], rejected[22], queued_top_priority[30:23].
  output logic [31:0] m_axis_tdata,
  // sent_valid.
  output logic        m_axis_tuser,
  output logic        m_axis_tlast
);
  import prfq_pkg::*;

  localparam int unsigned IW = $clog2(STORE_DEPTH);
  localparam int unsigned CW = $clog2(STORE_DEPTH + 1);

  localparam logic [1:0] StIdle    = 2'd0;
  localparam logic [1:0] StWalk    = 2'd1;
  localparam logic [1:0] StEmit    = 2'd2;
  localparam logic [1:0] StAckDone = 2'd3;

  slot_t      slots [STORE_DEPTH];
  cell_ctrl_t ctrl  [STORE_DEPTH];
  slot_t      head_new, wdata, h;

  logic [1:0]    state_q, state_d;
  logic [CW-1:0] cc_q, cc_d, sc_q, sc_d, step_q, step_d, rem_q, rem_d, total;
  logic [IW-1:0] ins_q, ins_d;
  logic [7:0]    ctop_q, ctop_d, stop_q, stop_d, rtop_q, rtop_d;
  logic [20:0]   maxps_q, size_q, size_d, req;
  logic [21:0]   sum;
  logic [15:0]   pid_q, pid_d;
  logic [5:0]    n_q, n_d, emit_q, emit_d;
  logic          send_q, send_d, halt_q, halt_d;
  logic          m_valid_q, m_valid_d;
  logic [5:0]    o_cnt_q, o_cnt_d;
  logic [15:0]   o_tag_q, o_tag_d;
  logic          o_sv_q, o_sv_d, o_last_q, o_last_d, o_rej_q, o_rej_d;
  logic [7:0]    o_top_q, o_top_d;
  logic          can_load, s_acc, shift, keep, wr_en, clr_en, ld, last_step, in_comm;
  logic          elig, rej;
  logic [2:0]    func;

  assign h         = slots[0];
  assign func      = s_axis_tuser;
  assign can_load  = !m_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == StIdle) && can_load;
  assign s_acc     = s_axis_tvalid && s_axis_tready;
  assign total     = cc_q + sc_q;
  assign last_step = (step_q == total - CW'(1));
  assign in_comm   = (step_q < cc_q);
  assign rej       = (total >= CW'(STORE_DEPTH));
  assign req       = {1'b0, h.len} + 21'(HEADER_BYTES);
  assign sum       = {1'b0, size_q} + {1'b0, req};

  always_comb begin
    wdata.tag  = s_axis_tdata[15:0];
    wdata.prio = s_axis_tdata[23:16];
    wdata.len  = s_axis_tdata[43:24];
    wdata.pkt  = '0;
    wdata.flag = 1'b0;
  end

  always_comb begin
    state_d  = state_q;
    cc_d     = cc_q;
    sc_d     = sc_q;
    ctop_d   = ctop_q;
    stop_d   = stop_q;
    step_d   = step_q;
    ins_d    = ins_q;
    rem_d    = rem_q;
    rtop_d   = rtop_q;
    size_d   = size_q;
    pid_d    = pid_q;
    n_d      = n_q;
    emit_d   = emit_q;
    send_d   = send_q;
    halt_d   = halt_q;
    head_new = h;
    keep     = 1'b1;
    shift    = 1'b0;
    wr_en    = 1'b0;
    clr_en   = 1'b0;
    elig     = 1'b0;
    ld       = 1'b0;
    o_cnt_d  = '0;
    o_tag_d  = '0;
    o_sv_d   = 1'b0;
    o_last_d = 1'b1;
    o_rej_d  = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (s_acc) begin
          unique case (func)
            FuncStage: begin
              ld = 1'b1;
              o_rej_d = rej;
              if (!rej) begin
                wr_en = 1'b1;
                sc_d  = sc_q + CW'(1);
                if (wdata.prio > stop_q) begin
                  stop_d = wdata.prio;
                end
              end
              o_cnt_d = sc_d[5:0];
            end
            FuncCommit: begin
              ld = 1'b1;
              if (sc_q != '0) begin
                cc_d = total;
                sc_d = '0;
                if (ctop_q < stop_q) begin
                  ctop_d = stop_q;
                end
                stop_d  = 8'd1;
                o_cnt_d = total[5:0];
              end
            end
            FuncSend, FuncAck: begin
              pid_d  = s_axis_tdata[59:44];
              send_d = (func == FuncSend);
              if (total == '0) begin
                ld = 1'b1;
                if (func == FuncAck) begin
                  ctop_d = 8'd1;
                end
              end else begin
                state_d = StWalk;
                step_d  = '0;
                ins_d   = IW'(total - CW'(1));
                n_d     = '0;
                size_d  = '0;
                halt_d  = 1'b0;
                rtop_d  = 8'd1;
                rem_d   = '0;
              end
            end
            FuncClear: begin
              ld = 1'b1;
              clr_en  = 1'b1;
              o_cnt_d = cc_q[5:0];
            end
            default: begin
              ld = 1'b1;
            end
          endcase
        end
      end
      StWalk: begin
        shift  = 1'b1;
        step_d = step_q + CW'(1);
        head_new.flag = 1'b0;
        if (send_q) begin
          if (in_comm && !halt_q && h.pkt == '0 && h.prio >= ctop_q &&
              n_q != 6'(MaxResults)) begin
            elig = 1'b1;
          end
          if (elig) begin
            if (sum < {1'b0, maxps_q}) begin
              head_new.flag = 1'b1;
              head_new.pkt  = pid_q;
              size_d = sum[20:0];
              n_d    = n_q + 6'd1;
            end else begin
              halt_d = 1'b1;
            end
          end
        end else if (in_comm) begin
          if (pid_q != '0 && h.pkt == pid_q) begin
            keep  = 1'b0;
            rem_d = rem_q + CW'(1);
            ins_d = ins_q - IW'(1);
          end else if (h.prio > rtop_q) begin
            rtop_d = h.prio;
          end
        end
        if (last_step) begin
          step_d = '0;
          if (send_q) begin
            state_d = StEmit;
            emit_d  = '0;
          end else begin
            state_d = StAckDone;
            cc_d    = cc_q - rem_d;
            ctop_d  = rtop_d;
          end
        end
      end
      StAckDone: begin
        if (can_load) begin
          ld      = 1'b1;
          o_cnt_d = rem_q[5:0];
          state_d = StIdle;
        end
      end
      default: begin
        if (n_q == '0) begin
          if (can_load) begin
            ld      = 1'b1;
            state_d = StIdle;
          end
        end else if (!h.flag || can_load) begin
          shift  = 1'b1;
          step_d = step_q + CW'(1);
          head_new.flag = 1'b0;
          if (h.flag) begin
            ld       = 1'b1;
            o_cnt_d  = n_q;
            o_tag_d  = h.tag;
            o_sv_d   = 1'b1;
            o_last_d = (emit_q + 6'd1 == n_q);
            emit_d   = emit_q + 6'd1;
          end
          if (last_step) begin
            state_d = StIdle;
          end
        end
      end
    endcase
    o_top_d = ctop_d;
    if (ld) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end else begin
      m_valid_d = m_valid_q;
    end
  end

  always_comb begin
    for (int j = 0; j < STORE_DEPTH; j++) begin
      ctrl[j].shift = shift;
      ctrl[j].ins   = keep && (IW'(j) == ins_q);
      ctrl[j].wr    = wr_en && (CW'(j) == total);
      ctrl[j].clr   = clr_en && (CW'(j) < cc_q);
    end
  end

  for (genvar g = 0; g < STORE_DEPTH; g++) begin : g_cell
    prfq_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl[g]),
      .nbr_i   ((g == STORE_DEPTH - 1) ? head_new : slots[(g + 1) % STORE_DEPTH]),
      .head_i  (head_new),
      .wdata_i (wdata),
      .slot_o  (slots[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      cc_q      <= '0;
      sc_q      <= '0;
      ctop_q    <= 8'd1;
      stop_q    <= 8'd1;
      maxps_q   <= PacketLimitReset;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cc_q      <= cc_d;
      sc_q      <= sc_d;
      ctop_q    <= ctop_d;
      stop_q    <= stop_d;
      m_valid_q <= m_valid_d;
      if (cfg_we_i) begin
        maxps_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    step_q <= step_d;
    ins_q  <= ins_d;
    rem_q  <= rem_d;
    rtop_q <= rtop_d;
    size_q <= size_d;
    pid_q  <= pid_d;
    n_q    <= n_d;
    emit_q <= emit_d;
    send_q <= send_d;
    halt_q <= halt_d;
    if (ld) begin
      o_cnt_q  <= o_cnt_d;
      o_tag_q  <= o_tag_d;
      o_sv_q   <= o_sv_d;
      o_last_q <= o_last_d;
      o_rej_q  <= o_rej_d;
      o_top_q  <= o_top_d;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {1'b0, o_top_q, o_rej_q, o_tag_q, o_cnt_q};
  assign m_axis_tuser  = o_sv_q;
  assign m_axis_tlast  = o_last_q;

endmodule

FILE: hdl/prfq_checker.sv
// ----------------------------------------------------------------------------
// prfq_checker: port-level checks of the priority frame send queue.
// Watches both stream channels and is bound to the top level.
// ----------------------------------------------------------------------------
module prfq_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic        m_axis_tuser,
  input logic        m_axis_tlast
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("Result word dropped while stalled.");

  a_no_take_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("Command taken while a result word waits.");

  a_sent_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[5:0] != 6'd0 && !m_axis_tdata[22])
    else $error("Sent word with zero count or reject flag.");

  a_reject_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[22] |-> m_axis_tlast && !m_axis_tuser)
    else $error("Rejected word is not a single final word.");

  a_top_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[30:23] != 8'd0)
    else $error("Queue priority gate fell below one.");

endmodule

bind priority_frame_send_queue_top prfq_checker u_prfq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
